### rtl/core/jrd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the journal record deframer.
// Holds the word structs, the phase enum, status codes and the FNV-1a constants.
package jrd_pkg;

	localparam int LENGTH_WIDTH = 32;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_TAIL = 2'd1;
	localparam logic [1:0] ST_NOTJ = 2'd2;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_VERSION,
		PH_LENGTH,
		PH_SUM,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       record_done;
		logic       file_done;
		logic [1:0] file_status;
	} out_t;

	// file magic: "CYJRNL", 0x00, 0x01
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h43;
			3'd1: b = 8'h59;
			3'd2: b = 8'h4A;
			3'd3: b = 8'h52;
			3'd4: b = 8'h4E;
			3'd5: b = 8'h4C;
			3'd6: b = 8'h00;
			3'd7: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### rtl/core/jrd_core.sv
`timescale 1ns / 1ps
// Deframing state machine: header check, record framing and FNV-1a hash.
// Depends on jrd_pkg; advances one word per cycle when step is high.
module jrd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  jrd_pkg::in_t        item,
	input  logic [31:0]         expected_version,
	output jrd_pkg::out_t       result
);

	localparam int LW = jrd_pkg::LENGTH_WIDTH;

	jrd_pkg::phase_t phase_q, phase_d;
	logic [LW-1:0]   cnt_q, cnt_d, cnt_inc;
	logic [31:0]     len_q, len_d;
	logic [31:0]     sum_q, sum_d;
	logic [31:0]     hash_q, hash_d, hash_mul;
	logic [31:0]     ver_q, ver_d;
	logic [1:0]      outc_q, outc_d;
	logic [31:0]     placed;
	logic            rec_done;
	logic            quad_end;

	assign cnt_inc  = cnt_q + LW'(1);
	assign placed   = 32'(item.data_byte) << {cnt_q[1:0], 3'b000};
	assign hash_mul = (hash_q ^ 32'(item.data_byte)) * jrd_pkg::FNV_PRIME;
	assign quad_end = (cnt_q[1:0] == 2'd3);

	// next state
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		sum_d    = sum_q;
		hash_d   = hash_q;
		ver_d    = ver_q;
		outc_d   = outc_q;
		rec_done = 1'b0;
		case (phase_q)
			jrd_pkg::PH_MAGIC: begin
				if (item.data_byte != jrd_pkg::magic_byte(cnt_q[2:0])) begin
					outc_d  = jrd_pkg::ST_NOTJ;
					phase_d = jrd_pkg::PH_SKIP;
				end else if (cnt_q[2:0] == 3'd7) begin
					cnt_d   = '0;
					phase_d = jrd_pkg::PH_VERSION;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			jrd_pkg::PH_VERSION: begin
				ver_d = ver_q | placed;
				if (quad_end) begin
					cnt_d = '0;
					if (ver_d != expected_version) begin
						outc_d  = jrd_pkg::ST_NOTJ;
						phase_d = jrd_pkg::PH_SKIP;
					end else begin
						phase_d = jrd_pkg::PH_LENGTH;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			jrd_pkg::PH_LENGTH: begin
				len_d = len_q | placed;
				if (quad_end) begin
					cnt_d = '0;
					if ((len_d >> LW) != 32'd0) begin
						outc_d  = jrd_pkg::ST_TAIL;
						phase_d = jrd_pkg::PH_SKIP;
					end else begin
						phase_d = jrd_pkg::PH_SUM;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			jrd_pkg::PH_SUM: begin
				sum_d = sum_q | placed;
				if (quad_end) begin
					cnt_d  = '0;
					hash_d = jrd_pkg::FNV_BASIS;
					if (len_q == 32'd0) begin
						// empty record: checked against the offset basis
						if (jrd_pkg::FNV_BASIS == sum_d) begin
							rec_done = 1'b1;
							phase_d  = jrd_pkg::PH_LENGTH;
							sum_d    = '0;
						end else begin
							outc_d  = jrd_pkg::ST_TAIL;
							phase_d = jrd_pkg::PH_SKIP;
						end
					end else begin
						phase_d = jrd_pkg::PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			jrd_pkg::PH_PAYLOAD: begin
				hash_d = hash_mul;
				cnt_d  = cnt_inc;
				if (cnt_inc == len_q[LW-1:0]) begin
					if (hash_mul == sum_q) begin
						rec_done = 1'b1;
						phase_d  = jrd_pkg::PH_LENGTH;
						len_d    = '0;
						sum_d    = '0;
						hash_d   = jrd_pkg::FNV_BASIS;
						cnt_d    = '0;
					end else begin
						outc_d  = jrd_pkg::ST_TAIL;
						phase_d = jrd_pkg::PH_SKIP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		result               = '0;
		result.payload_valid = (phase_q == jrd_pkg::PH_PAYLOAD);
		result.payload_byte  = (phase_q == jrd_pkg::PH_PAYLOAD) ? item.data_byte : 8'd0;
		result.record_done   = rec_done;
		result.file_done     = item.last_byte;
		if (item.last_byte) begin
			case (phase_d)
				jrd_pkg::PH_MAGIC,
				jrd_pkg::PH_VERSION: result.file_status = jrd_pkg::ST_NOTJ;
				jrd_pkg::PH_LENGTH:  result.file_status =
					(cnt_d == '0) ? jrd_pkg::ST_OK : jrd_pkg::ST_TAIL;
				jrd_pkg::PH_SUM,
				jrd_pkg::PH_PAYLOAD: result.file_status = jrd_pkg::ST_TAIL;
				default:             result.file_status = outc_d;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jrd_pkg::PH_MAGIC;
			cnt_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			hash_q  <= jrd_pkg::FNV_BASIS;
			ver_q   <= '0;
			outc_q  <= jrd_pkg::ST_OK;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= jrd_pkg::PH_MAGIC;
				cnt_q   <= '0;
				len_q   <= '0;
				sum_q   <= '0;
				hash_q  <= jrd_pkg::FNV_BASIS;
				ver_q   <= '0;
				outc_q  <= jrd_pkg::ST_OK;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				len_q   <= len_d;
				sum_q   <= sum_d;
				hash_q  <= hash_d;
				ver_q   <= ver_d;
				outc_q  <= outc_d;
			end
		end
	end

endmodule

### rtl/core/journal_record_deframer.sv
`timescale 1ns / 1ps
// Journal record deframer top level: input register, deframing core, result register.
// Depends on jrd_pkg and jrd_core.
//
// Usage: the input channel (in_valid, in_stall, in_word) takes one file byte per
// word, with last_byte marking the final byte of a file. The output channel
// (out_valid, out_stall, out_word) returns exactly one result word per input
// word, in order: a payload byte when payload_valid is set, record_done on the
// byte that closes a record whose FNV-1a checksum matched, and file_done with
// file_status on the last byte. Payload of a record that never completes must
// be dropped downstream.
// Each input word is registered in the input register and its result in the result
// register, which drives out_valid. Throughput is one word per cycle while out_stall
// is low; the core's hash update is one 32-bit multiply.
// Reset clears all file state and sets expected_version to 1; cfg_we/cfg_data
// rewrite it and should only be used while idle. When out_stall and out_valid are
// both high, the result register holds, the input register fills, and then in_stall
// rises. After the last byte of a file the core returns to the header phase.
module journal_record_deframer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  jrd_pkg::in_t   in_word,
	output logic           out_valid,
	input  logic           out_stall,
	output jrd_pkg::out_t  out_word,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data
);

	logic          valid_s1;
	jrd_pkg::in_t  item_s1;
	logic          out_valid_q;
	jrd_pkg::out_t out_word_q;
	jrd_pkg::out_t result;
	logic [31:0]   version_q;
	logic          advance;
	logic          step;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 32'd1;
		end else if (cfg_we) begin
			version_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_word;
		end
	end

	jrd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.item             (item_s1),
		.expected_version (version_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
